// ----- rtl/nups_pkg.sv -----
// Package for the nearest unvisited point search block.
// Holds sizes, item kinds and the request and result struct types; no dependencies.
package nups_pkg;
    localparam int MAX_NODES  = 1024;
    localparam int COORD_BITS = 10;
    localparam int FRAC_BITS  = 8;
    localparam int IDX_BITS   = 11;
    localparam int ADDR_BITS  = 10;
    localparam int COST_BITS  = 29;
    localparam int DSQ_BITS   = 2 * COORD_BITS + 1;
    localparam int ROOT_BITS  = COORD_BITS + 1 + FRAC_BITS;
    localparam logic [COST_BITS-1:0] COST_MAX = '1;

    typedef enum logic [1:0] {
        KIND_LOAD    = 2'd0,
        KIND_CLOSEST = 2'd1,
        KIND_TOUR    = 2'd2,
        KIND_NOP     = 2'd3
    } kind_t;

    typedef struct packed {
        logic [1:0]            kind;
        logic [IDX_BITS-1:0]   node_index;
        logic [COORD_BITS-1:0] coord_x;
        logic [COORD_BITS-1:0] coord_y;
        logic                  tour_last;
    } request_t;

    typedef struct packed {
        logic [IDX_BITS-1:0]  closest_node;
        logic                 found;
        logic                 bad_index;
        logic [COST_BITS-1:0] tour_cost;
        logic                 cost_valid;
    } result_t;
endpackage

// ----- rtl/nearest_unvisited_point_search_top.sv -----
// Nearest unvisited point search: point table, visited marks, tour cost.
// Depends on nups_pkg, nups_ram and nups_sqrt.
// A closest request scans the point RAM, one point read per cycle; a tour
// step waits on the iterative square root for each edge length.
// One request at a time: busy stays high until the result strobe.
// Reset: a sweep over all MAX_NODES entries clears the visited-mark RAM; busy
// holds high meanwhile, configuration writes are taken as ever.
module nearest_unvisited_point_search_top
    import nups_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    output logic                 busy,
    input  request_t             request,
    output logic                 done,
    output result_t              result,
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [1:0]           paddr,
    input  logic [31:0]          pwdata,
    output logic [31:0]          prdata,
    output logic                 pready
);
    typedef enum logic [12:0] {
        ST_CLEAR = 13'b0000000000001,
        ST_IDLE  = 13'b0000000000010,
        ST_LOAD  = 13'b0000000000100,
        ST_QRD   = 13'b0000000001000,  // read query point
        ST_QWAIT = 13'b0000000010000,
        ST_SCAN  = 13'b0000000100000,  // issue one point read per cycle
        ST_DRAIN = 13'b0000001000000,
        ST_MARK  = 13'b0000010000000,
        ST_ERD   = 13'b0000100000000,  // read edge endpoints
        ST_EWAIT = 13'b0001000000000,
        ST_ESQ   = 13'b0010000000000,  // form squared distance, start root
        ST_ERT   = 13'b0100000000000,  // wait for square root
        ST_DONE  = 13'b1000000000000
    } state_t;

    state_t state_reg, state_next;

    // Configuration register
    logic [IDX_BITS-1:0] node_count_reg;
    logic                cfg_wr;
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && (paddr == 2'd0);
    assign prdata = {21'd0, node_count_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            node_count_reg <= IDX_BITS'(MAX_NODES);
        end
        else if (cfg_wr)
        begin
            node_count_reg <= pwdata[IDX_BITS-1:0];
        end
    end

    logic [IDX_BITS-1:0] n_act;
    assign n_act = (node_count_reg > IDX_BITS'(MAX_NODES)) ? IDX_BITS'(MAX_NODES)
                                                           : node_count_reg;

    // Point and mark memories, addressed by index minus one
    logic                        pt_we, mk_we, mk_wdata, mk_rdata;
    logic [ADDR_BITS-1:0]        pt_waddr, pt_raddr, mk_waddr, mk_raddr;
    logic [2*COORD_BITS-1:0]     pt_wdata, pt_rdata;

    nups_ram #(.WIDTH(2*COORD_BITS), .DEPTH(MAX_NODES)) u_pt_ram (
        .clk(clk), .we(pt_we), .waddr(pt_waddr), .wdata(pt_wdata),
        .raddr(pt_raddr), .rdata(pt_rdata)
    );
    nups_ram #(.WIDTH(1), .DEPTH(MAX_NODES)) u_mk_ram (
        .clk(clk), .we(mk_we), .waddr(mk_waddr), .wdata(mk_wdata),
        .raddr(mk_raddr), .rdata(mk_rdata)
    );

    // Square-root unit
    logic                 sq_start, sq_done;
    logic [DSQ_BITS-1:0]  sq_in;
    logic [ROOT_BITS-1:0] sq_root;
    nups_sqrt u_sqrt (
        .clk(clk), .rst_n(rst_n), .start(sq_start), .radicand(sq_in),
        .done(sq_done), .root(sq_root)
    );

    // Working registers
    request_t               req_reg;
    logic                   ok_reg;
    logic [ADDR_BITS:0]     cnt_reg, cnt_next;       // sweep / issue counter
    logic [ADDR_BITS:0]     pipe_idx_reg;            // index of point in read stage
    logic                   pipe_v_reg;
    logic [COORD_BITS-1:0]  qx_reg, qy_reg;
    logic [DSQ_BITS-1:0]    best_reg;
    logic [IDX_BITS-1:0]    best_node_reg;
    logic [COORD_BITS-1:0]  ax_reg, ay_reg;
    logic                   second_reg;              // closing edge pending
    logic [IDX_BITS-1:0]    tour_start_reg, tour_prev_reg;
    logic [COST_BITS-1:0]   cost_sum_reg;
    logic                   in_tour_reg;
    logic                   tour_open_reg;           // this step opened the tour
    result_t                res_reg;
    logic                   done_reg;

    logic                   accept, q_ok;
    logic [IDX_BITS-1:0]    e_a, e_b;
    logic [COORD_BITS-1:0]  px, py;
    logic [COORD_BITS:0]    ddx, ddy;
    logic [COORD_BITS:0]    e_dx, e_dy;
    logic [DSQ_BITS-1:0]    d_scan;
    logic [COST_BITS:0]     cost_add;

    assign accept = start && !busy;
    assign busy   = (state_reg != ST_IDLE);
    assign q_ok   = (request.node_index != '0) && (request.node_index <= n_act);
    assign px     = pt_rdata[2*COORD_BITS-1:COORD_BITS];
    assign py     = pt_rdata[COORD_BITS-1:0];

    // Distance of the point leaving the RAM to the query point
    always_comb
    begin
        ddx    = (px >= qx_reg) ? {1'b0, px - qx_reg} : {1'b0, qx_reg - px};
        ddy    = (py >= qy_reg) ? {1'b0, py - qy_reg} : {1'b0, qy_reg - py};
        d_scan = DSQ_BITS'(ddx * ddx) + DSQ_BITS'(ddy * ddy);
    end

    // Edge length input: second endpoint leaving the RAM against the first
    always_comb
    begin
        e_dx  = (px >= ax_reg) ? {1'b0, px - ax_reg} : {1'b0, ax_reg - px};
        e_dy  = (py >= ay_reg) ? {1'b0, py - ay_reg} : {1'b0, ay_reg - py};
        sq_in = DSQ_BITS'(e_dx * e_dx) + DSQ_BITS'(e_dy * e_dy);
    end

    // Edge endpoints: normal edge prev->new, closing edge prev->start
    assign e_a      = tour_prev_reg;
    assign e_b      = second_reg ? tour_start_reg : req_reg.node_index;
    assign cost_add = {1'b0, cost_sum_reg} + (COST_BITS+1)'(sq_root);
    assign sq_start = (state_reg == ST_ESQ);

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        pt_we      = 1'b0;
        pt_waddr   = ADDR_BITS'(req_reg.node_index - 1'b1);
        pt_wdata   = {req_reg.coord_x, req_reg.coord_y};
        pt_raddr   = ADDR_BITS'(req_reg.node_index - 1'b1);
        mk_we      = 1'b0;
        mk_waddr   = ADDR_BITS'(req_reg.node_index - 1'b1);
        mk_wdata   = 1'b0;
        mk_raddr   = cnt_reg[ADDR_BITS-1:0];
        unique case (state_reg)
            ST_CLEAR:
            begin
                mk_we    = 1'b1;
                mk_waddr = cnt_reg[ADDR_BITS-1:0];
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == (ADDR_BITS+1)'(MAX_NODES - 1))
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (accept)
                begin
                    unique case (request.kind)
                        KIND_LOAD:    state_next = ST_LOAD;
                        KIND_CLOSEST: state_next = q_ok ? ST_QRD : ST_DONE;
                        KIND_TOUR:    state_next = ST_ERD;
                        default:      state_next = ST_DONE;
                    endcase
                end
            end
            ST_LOAD:
            begin
                // write point and clear its mark
                pt_we      = ok_reg;
                mk_we      = ok_reg;
                state_next = ST_DONE;
            end
            ST_QRD:
            begin
                // mark the query node, fetch its point
                mk_we      = 1'b1;
                mk_wdata   = 1'b1;
                state_next = ST_QWAIT;
                cnt_next   = '0;
            end
            ST_QWAIT:
            begin
                state_next = ST_SCAN;
            end
            ST_SCAN:
            begin
                pt_raddr = cnt_reg[ADDR_BITS-1:0];
                mk_raddr = cnt_reg[ADDR_BITS-1:0];
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == (ADDR_BITS+1)'(n_act - 1'b1))
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                state_next = ST_MARK;
            end
            ST_MARK:
            begin
                mk_we      = (best_node_reg != '0);
                mk_waddr   = ADDR_BITS'(best_node_reg - 1'b1);
                mk_wdata   = 1'b1;
                state_next = ST_DONE;
            end
            ST_ERD:
            begin
                pt_raddr   = ADDR_BITS'(e_a - 1'b1);
                state_next = ST_EWAIT;
            end
            ST_EWAIT:
            begin
                pt_raddr   = ADDR_BITS'(e_b - 1'b1);
                state_next = ST_ESQ;
            end
            ST_ESQ:
            begin
                state_next = ST_ERT;
            end
            ST_ERT:
            begin
                if (sq_done)
                begin
                    state_next = (second_reg || !req_reg.tour_last) ? ST_DONE : ST_ERD;
                end
            end
            ST_DONE:
            begin
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_CLEAR;
            cnt_reg        <= '0;
            pipe_v_reg     <= 1'b0;
            done_reg       <= 1'b0;
            in_tour_reg    <= 1'b0;
            tour_start_reg <= '0;
            tour_prev_reg  <= '0;
            cost_sum_reg   <= '0;
            second_reg     <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            cnt_reg    <= cnt_next;
            pipe_v_reg <= (state_reg == ST_SCAN);
            done_reg   <= (state_reg == ST_DONE);
            if (state_reg == ST_IDLE && accept && request.kind == KIND_TOUR)
            begin
                second_reg <= 1'b0;
                // a valid step that opens a tour needs no edge
                if (q_ok && !in_tour_reg)
                begin
                    tour_start_reg <= request.node_index;
                    tour_prev_reg  <= request.node_index;
                    cost_sum_reg   <= '0;
                    in_tour_reg    <= 1'b1;
                end
            end
            if (state_reg == ST_ERT && sq_done)
            begin
                // drop the edge when no tour open, index bad or this step opened the tour
                if (second_reg ? in_tour_reg : (ok_reg && in_tour_reg && !tour_open_reg))
                begin
                    cost_sum_reg <= cost_add[COST_BITS] ? COST_MAX
                                                        : cost_add[COST_BITS-1:0];
                end
                if (!second_reg && ok_reg)
                begin
                    tour_prev_reg <= req_reg.node_index;
                end
                if (!second_reg && req_reg.tour_last)
                begin
                    second_reg <= 1'b1;
                end
            end
            if (state_reg == ST_DONE && req_reg.kind == KIND_TOUR && req_reg.tour_last)
            begin
                in_tour_reg <= 1'b0;
                if (!in_tour_reg)
                begin
                    cost_sum_reg <= '0;
                end
            end
        end
    end

    // set when this step itself opened the tour (no edge to add)
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tour_open_reg <= 1'b0;
        end
        else if (state_reg == ST_IDLE && accept)
        begin
            tour_open_reg <= q_ok && !in_tour_reg;
        end
    end

    // Datapath registers
    always_ff @(posedge clk)
    begin
        if (state_reg == ST_IDLE && accept)
        begin
            req_reg <= request;
            ok_reg  <= q_ok;
        end
        if (state_reg == ST_QWAIT)
        begin
            qx_reg        <= px;
            qy_reg        <= py;
            best_node_reg <= '0;
            best_reg      <= '0;
        end
        pipe_idx_reg <= cnt_reg + 1'b1;
        // compare point read last cycle; ties go to the later index
        if (pipe_v_reg && !mk_rdata)
        begin
            if (best_node_reg == '0 || d_scan <= best_reg)
            begin
                best_reg      <= d_scan;
                best_node_reg <= IDX_BITS'(pipe_idx_reg);
            end
        end
        if (state_reg == ST_EWAIT)
        begin
            ax_reg <= px;
            ay_reg <= py;
        end
    end

    // Result assembly
    always_comb
    begin
        res_reg = '0;
        if (req_reg.kind != KIND_NOP)
        begin
            res_reg.bad_index = !ok_reg;
        end
        if (req_reg.kind == KIND_CLOSEST && ok_reg)
        begin
            res_reg.closest_node = best_node_reg;
            res_reg.found        = (best_node_reg != '0);
        end
        if (req_reg.kind == KIND_TOUR && req_reg.tour_last)
        begin
            res_reg.cost_valid = 1'b1;
            res_reg.tour_cost  = in_tour_reg ? cost_sum_reg : '0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_DONE)
        begin
            result <= res_reg;
        end
    end

    assign done = done_reg;
endmodule

// ----- rtl/nups_ram.sv -----
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module nups_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

// ----- rtl/nups_sqrt.sv -----
// Iterative fixed-point square root, one result bit per cycle.
// Depends on nups_pkg.
module nups_sqrt
    import nups_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  logic [DSQ_BITS-1:0]  radicand,
    output logic                 done,
    output logic [ROOT_BITS-1:0] root
);
    localparam int SH_BITS  = 2 * ROOT_BITS;
    localparam int REM_BITS = ROOT_BITS + 2;
    localparam int CNT_BITS = $clog2(ROOT_BITS + 1);

    logic [SH_BITS-1:0]   sh_reg, sh_next;
    logic [REM_BITS-1:0]  rem_reg, rem_next;
    logic [ROOT_BITS-1:0] root_reg, root_next;
    logic [CNT_BITS-1:0]  cnt_reg, cnt_next;
    logic                 run_reg, run_next;
    logic                 done_reg, done_next;
    logic [REM_BITS-1:0]  rem_sh, trial;

    always_comb
    begin
        sh_next   = sh_reg;
        rem_next  = rem_reg;
        root_next = root_reg;
        cnt_next  = cnt_reg;
        run_next  = run_reg;
        done_next = 1'b0;
        rem_sh    = {rem_reg[REM_BITS-3:0], sh_reg[SH_BITS-1 -: 2]};
        trial     = {root_reg, 2'b01};
        if (start)
        begin
            sh_next   = {{(SH_BITS-DSQ_BITS-2*FRAC_BITS){1'b0}}, radicand,
                         {(2*FRAC_BITS){1'b0}}};
            rem_next  = '0;
            root_next = '0;
            cnt_next  = CNT_BITS'(ROOT_BITS);
            run_next  = 1'b1;
        end
        else if (run_reg)
        begin
            sh_next = {sh_reg[SH_BITS-3:0], 2'b00};
            if (rem_sh >= trial)
            begin
                rem_next  = rem_sh - trial;
                root_next = {root_reg[ROOT_BITS-2:0], 1'b1};
            end
            else
            begin
                rem_next  = rem_sh;
                root_next = {root_reg[ROOT_BITS-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CNT_BITS'(1))
            begin
                run_next  = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            run_reg  <= run_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        sh_reg   <= sh_next;
        rem_reg  <= rem_next;
        root_reg <= root_next;
    end

    assign done = done_reg;
    assign root = root_reg;
endmodule

// ----- sim/nups_checker.sv -----
// Checker for the nearest unvisited point search block: predicts and compares every result.
// Depends on nups_pkg; watches the request, result and configuration channels of the top.
module nups_checker
    import nups_pkg::*;
#(
    parameter logic [1:0] NODE_COUNT_ADDR = 2'd0
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic        busy,
    input  request_t    request,
    input  logic        done,
    input  result_t     result,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [1:0]  paddr,
    input  logic [31:0] pwdata,
    input  logic        pready,
    output int          failures,
    output int          waiting,
    output int          requests_seen,
    output int          results_seen
);
    logic [COORD_BITS-1:0] point_x [1:MAX_NODES];
    logic [COORD_BITS-1:0] point_y [1:MAX_NODES];
    bit                    taken   [1:MAX_NODES];
    logic [IDX_BITS-1:0]   node_limit;
    int                    first_node;
    int                    last_node;
    longint unsigned       length_sum;
    bit                    touring;
    result_t               expected_q [$];

    function automatic longint unsigned gap_sq(int a, int b);
        longint dx;
        longint dy;
        dx = longint'(point_x[a]) - longint'(point_x[b]);
        dy = longint'(point_y[a]) - longint'(point_y[b]);
        return longint'(dx * dx + dy * dy);
    endfunction

    // floor(sqrt(d) * 2^FRAC_BITS) by setting root bits from the top down
    function automatic longint unsigned edge_length(longint unsigned dsq);
        longint unsigned target;
        longint unsigned root;
        longint unsigned trial;
        target = dsq << (2 * FRAC_BITS);
        root   = 0;
        for (int b = ROOT_BITS - 1; b >= 0; b--)
        begin
            trial = root | (64'd1 << b);
            if (trial * trial <= target)
                root = trial;
        end
        return root;
    endfunction

    function automatic void add_edge(int a, int b);
        length_sum += edge_length(gap_sq(a, b));
        if (length_sum > COST_MAX)
            length_sum = COST_MAX;
    endfunction

    function automatic result_t predict_result(request_t r);
        result_t         res;
        int              n;
        int              idx;
        bit              ok;
        kind_t           k;
        longint unsigned best;
        longint unsigned d;
        int              best_node;
        res  = '0;
        n    = (node_limit > MAX_NODES) ? MAX_NODES : int'(node_limit);
        idx  = int'(r.node_index);
        ok   = (idx >= 1) && (idx <= n);
        k    = kind_t'(r.kind);
        best = 0;
        best_node = 0;
        if (k != KIND_NOP && !ok)
            res.bad_index = 1'b1;
        case (k)
            KIND_LOAD:
            begin
                if (ok)
                begin
                    point_x[idx] = r.coord_x;
                    point_y[idx] = r.coord_y;
                    taken[idx]   = 1'b0;
                end
            end
            KIND_CLOSEST:
            begin
                if (ok)
                begin
                    taken[idx] = 1'b1;
                    for (int i = 1; i <= n; i++)
                    begin
                        if (!taken[i])
                        begin
                            d = gap_sq(idx, i);
                            if (best_node == 0 || d <= best)
                            begin
                                best      = d;
                                best_node = i;
                            end
                        end
                    end
                    if (best_node != 0)
                    begin
                        taken[best_node] = 1'b1;
                        res.closest_node = IDX_BITS'(best_node);
                        res.found        = 1'b1;
                    end
                end
            end
            KIND_TOUR:
            begin
                if (ok)
                begin
                    if (!touring)
                    begin
                        first_node = idx;
                        last_node  = idx;
                        length_sum = 0;
                        touring    = 1'b1;
                    end
                    else
                    begin
                        add_edge(last_node, idx);
                        last_node = idx;
                    end
                end
                if (r.tour_last)
                begin
                    if (touring)
                        add_edge(last_node, first_node);
                    else
                        length_sum = 0;
                    res.tour_cost  = COST_BITS'(length_sum);
                    res.cost_valid = 1'b1;
                    touring        = 1'b0;
                end
            end
            default: ;
        endcase
        return res;
    endfunction

    task automatic check_field(string name, longint unsigned want, longint unsigned got);
        if (want != got)
        begin
            failures++;
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        result_t want;
        if (!rst_n)
        begin
            for (int i = 1; i <= MAX_NODES; i++)
                taken[i] = 1'b0;
            node_limit    = IDX_BITS'(MAX_NODES);
            first_node    = 0;
            last_node     = 0;
            length_sum    = 0;
            touring       = 1'b0;
            failures      = 0;
            requests_seen = 0;
            results_seen  = 0;
            expected_q.delete();
        end
        else
        begin
            if (psel && penable && pwrite && pready && paddr == NODE_COUNT_ADDR)
                node_limit = pwdata[IDX_BITS-1:0];
            if (start && !busy)
            begin
                expected_q.push_back(predict_result(request));
                requests_seen++;
            end
            if (done)
            begin
                results_seen++;
                if (expected_q.size() == 0)
                begin
                    failures++;
                    $display("%0t: result with nothing expected, actual %h", $time, result);
                end
                else
                begin
                    want = expected_q.pop_front();
                    check_field("closest_node", want.closest_node, result.closest_node);
                    check_field("found", want.found, result.found);
                    check_field("bad_index", want.bad_index, result.bad_index);
                    check_field("tour_cost", want.tour_cost, result.tour_cost);
                    check_field("cost_valid", want.cost_valid, result.cost_valid);
                end
            end
        end
        waiting = expected_q.size();
    end
endmodule

// ----- sim/tb.sv -----
// Testbench top for nearest_unvisited_point_search_top: clock, reset, stimulus and verdict.
// Depends on nups_pkg, the block's RTL and nups_checker, which predicts and compares.
module tb;
    import nups_pkg::*;

    localparam logic [1:0] NODE_COUNT_ADDR = 2'd0;
    localparam int         QUIET_LIMIT     = 20000;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        start = 1'b0;
    logic        busy;
    request_t    request = '0;
    logic        done;
    result_t     result;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [1:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    int failures;
    int waiting;
    int requests_seen;
    int results_seen;
    int quiet_cycles = 0;
    int idle_pct = 0;
    int active_nodes = MAX_NODES;
    bit loaded [1:MAX_NODES];

    always #10 clk = ~clk;

    nearest_unvisited_point_search_top dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .busy    (busy),
        .request (request),
        .done    (done),
        .result  (result),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    nups_checker #(.NODE_COUNT_ADDR(NODE_COUNT_ADDR)) u_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .request       (request),
        .done          (done),
        .result        (result),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .pready        (pready),
        .failures      (failures),
        .waiting       (waiting),
        .requests_seen (requests_seen),
        .results_seen  (results_seen)
    );

    // Watchdog: end the run when nothing moves for too long. The limit leaves
    // ample room for a full-size closest scan.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((start && !busy) || done)
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles == QUIET_LIMIT)
            begin
                $display("[nearest_unvisited_point_search_top] ERROR");
                $finish;
            end
        end
    end

    // Issue one request; hold start until the block takes it. Random sender
    // gaps go in front, with start low, so they land on every phase of work.
    task automatic send_request(kind_t k, int idx, int x, int y, bit last);
        while ($urandom_range(99, 0) < idle_pct)
        begin
            start <= 1'b0;
            @(posedge clk);
        end
        start              <= 1'b1;
        request.kind       <= k;
        request.node_index <= IDX_BITS'(idx);
        request.coord_x    <= COORD_BITS'(x);
        request.coord_y    <= COORD_BITS'(y);
        request.tour_last  <= last;
        do
            @(posedge clk);
        while (busy);
        if (k == KIND_LOAD && idx >= 1 && idx <= active_nodes)
            loaded[idx] = 1'b1;
    endtask

    task automatic load_point(int idx, int x, int y);
        send_request(KIND_LOAD, idx, x, y, 1'b0);
    endtask

    // Drain: drop start and wait until every expected result has come back.
    task automatic drain();
        start <= 1'b0;
        @(posedge clk);
        while (waiting != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    // Write node_count through the APB port: setup cycle, then access cycle.
    task automatic set_node_count(int value);
        drain();
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= NODE_COUNT_ADDR;
        pwdata  <= 32'(value);
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
        active_nodes = (value & 11'h7FF) > MAX_NODES ? MAX_NODES : (value & 11'h7FF);
    endtask

    // Load every point in use that has never been written, so no scan or
    // tour ever reads an empty table entry.
    task automatic fill_points();
        for (int i = 1; i <= active_nodes; i++)
            if (!loaded[i])
                load_point(i, $urandom_range(1023, 0), $urandom_range(1023, 0));
    endtask

    function automatic int valid_index();
        return $urandom_range(active_nodes, 1);
    endfunction

    function automatic int invalid_index();
        if ($urandom_range(3, 0) == 0)
            return 0;
        return $urandom_range(2047, active_nodes + 1);
    endfunction

    // One random step: mostly well-formed loads, closest chains and tours,
    // with bad indices and no-ops as noise.
    task automatic random_step();
        int pick;
        int len;
        int idx;
        pick = $urandom_range(99, 0);
        if (pick < 30)
            load_point(valid_index(), $urandom_range(1023, 0), $urandom_range(1023, 0));
        else if (pick < 55)
            send_request(KIND_CLOSEST, valid_index(), $urandom, $urandom, $urandom);
        else if (pick < 62)
            send_request(kind_t'($urandom_range(2, 0)), invalid_index(),
                         $urandom, $urandom, $urandom);
        else if (pick < 65)
            send_request(KIND_NOP, $urandom, $urandom, $urandom, $urandom);
        else
        begin
            len = $urandom_range(6, 1);
            for (int j = 0; j < len; j++)
            begin
                idx = ($urandom_range(9, 0) == 0) ? invalid_index() : valid_index();
                send_request(KIND_TOUR, idx, $urandom, $urandom, j == len - 1);
            end
        end
    endtask

    task automatic random_phase(int count);
        fill_points();
        repeat (count) random_step();
    endtask

    initial
    begin
        for (int i = 1; i <= MAX_NODES; i++)
            loaded[i] = 1'b0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part: corners, a tie, exhaustion, bad indices, tours.
        idle_pct = 6;
        set_node_count(6);
        load_point(1, 0, 0);
        load_point(2, 1023, 1023);
        load_point(3, 10, 0);
        load_point(4, 0, 10);
        load_point(5, 1023, 0);
        load_point(6, 0, 1023);
        send_request(KIND_CLOSEST, 1, 0, 0, 1'b0);      // tie between 3 and 4
        send_request(KIND_CLOSEST, 5, 0, 0, 1'b0);
        send_request(KIND_CLOSEST, 6, 0, 0, 1'b0);      // takes the last unvisited node
        load_point(0, 5, 5);
        load_point(7, 5, 5);
        send_request(KIND_CLOSEST, 2047, 0, 0, 1'b0);
        send_request(KIND_NOP, 2047, 1023, 1023, 1'b1);
        send_request(KIND_TOUR, 1, 0, 0, 1'b0);
        send_request(KIND_TOUR, 2, 0, 0, 1'b0);
        send_request(KIND_TOUR, 5, 0, 0, 1'b0);
        send_request(KIND_TOUR, 6, 0, 0, 1'b1);
        send_request(KIND_TOUR, 3, 0, 0, 1'b1);         // single-node tour
        send_request(KIND_TOUR, 0, 0, 0, 1'b1);         // empty tour
        send_request(KIND_TOUR, 1, 0, 0, 1'b0);
        send_request(KIND_TOUR, 9, 0, 0, 1'b0);
        send_request(KIND_TOUR, 2, 0, 0, 1'b1);
        set_node_count(1);
        send_request(KIND_CLOSEST, 1, 0, 0, 1'b0);
        send_request(KIND_CLOSEST, 2, 0, 0, 1'b0);

        // Random phases: sender idles rarely, then often, then never.
        set_node_count(12);
        random_phase(90);
        idle_pct = 86;
        set_node_count(37);
        random_phase(90);
        idle_pct = 0;
        set_node_count(60);
        random_phase(80);

        // Oversized node count clamps to the table size.
        set_node_count(2047);
        load_point(1024, 7, 9);
        load_point(1025, 1, 1);
        send_request(KIND_CLOSEST, 2047, 0, 0, 1'b0);

        drain();
        repeat (20) @(posedge clk);
        $display("Run covered %0d requests and %0d results over node counts 1 to 2047,",
                 requests_seen, results_seen);
        $display("with loads, closest chains, tours, bad indices and idle-sender gaps.");
        if (failures == 0)
            $display("[nearest_unvisited_point_search_top] OK");
        else
            $display("[nearest_unvisited_point_search_top] ERROR");
        $finish;
    end
endmodule
